// ----- hdl/cpu_alu_pkg.sv -----
package cpu_alu_pkg;

  typedef enum logic [5:0] {
    ADC   = 6'd0,
    AND_M = 6'd1,
    ASL   = 6'd2,
    BIT   = 6'd3,
    CLC   = 6'd4,
    CLI   = 6'd5,
    CLD   = 6'd6,
    CLV   = 6'd7,
    CMP   = 6'd8,
    CPX   = 6'd9,
    CPY   = 6'd10,
    DEC   = 6'd11,
    DEX   = 6'd12,
    DEY   = 6'd13,
    EOR   = 6'd14,
    INC   = 6'd15,
    INX   = 6'd16,
    INY   = 6'd17,
    LDA   = 6'd18,
    LDX   = 6'd19,
    LDY   = 6'd20,
    LSR   = 6'd21,
    ORA   = 6'd22,
    ROL   = 6'd23,
    ROR   = 6'd24,
    SBC   = 6'd25,
    SEC   = 6'd26,
    SED   = 6'd27,
    SEI   = 6'd28,
    STA   = 6'd29,
    STX   = 6'd30,
    STY   = 6'd31,
    TAX   = 6'd32,
    TAY   = 6'd33,
    TSX   = 6'd34,
    TXA   = 6'd35,
    TXS   = 6'd36,
    TYA   = 6'd37,
    ASL_A = 6'd38,
    LSR_A = 6'd39,
    ROL_A = 6'd40,
    ROR_A = 6'd41,
    DCP   = 6'd42,
    LAX   = 6'd43,
    SAX   = 6'd44,
    ISB   = 6'd45,
    SLO   = 6'd46,
    RLA   = 6'd47,
    SRE   = 6'd48,
    RRA   = 6'd49,
    NOP   = 6'd50
  } kind_t;

  // processor flags as held in the block
  typedef struct packed {
    logic n;
    logic v;
    logic d;
    logic i;
    logic z;
    logic c;
  } flags_t;

  localparam logic [7:0] SP_RESET = 8'hFD;

endpackage

// ----- hdl/cpu_alu_execute_unit.sv -----
// Execute unit holding A, X, Y, SP and the N V D I Z C flags. Each accepted item
// (operation kind, operand byte, effective address) is latched in an input
// register, executed against the register file, and its result (memory write,
// all registers after the operation, status byte) is written to an output
// register. One item is taken every cycle unless out_ready stalls the output:
// the rate is set by the register feedback through the adder/shift/logic path,
// so an item sees the registers left by the item before it. Bits 5 and 4 of the
// status byte read as zero, D is stored only (no decimal mode), and unused kinds
// act as NOP.
module cpu_alu_execute_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [5:0]  kind,
  input  logic [7:0]  operand,
  input  logic [15:0] mem_address,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        mem_write,
  output logic [15:0] write_address,
  output logic [7:0]  write_data,
  output logic [7:0]  acc_out,
  output logic [7:0]  x_out,
  output logic [7:0]  y_out,
  output logic [7:0]  sp_out,
  output logic [7:0]  status_out
);

  // input register
  logic                 op_valid;
  cpu_alu_pkg::kind_t   op_kind;
  logic [7:0]           op_m;
  logic [15:0]          op_addr;

  // architectural state
  logic [7:0]           acc;
  logic [7:0]           xr;
  logic [7:0]           yr;
  logic [7:0]           sp;
  cpu_alu_pkg::flags_t  flags;

  logic [7:0]           acc_next;
  logic [7:0]           xr_next;
  logic [7:0]           yr_next;
  logic [7:0]           sp_next;
  cpu_alu_pkg::flags_t  flags_next;
  logic                 wr;
  logic [7:0]           wd;

  logic                 add_en;
  logic [7:0]           add_m;
  logic                 add_cin;
  logic [8:0]           sum;
  logic                 cmp_en;
  logic [7:0]           cmp_reg;
  logic [7:0]           cmp_m;
  logic [8:0]           diff;
  logic                 nz_en;
  logic [7:0]           nz_val;

  logic                 advance;

  assign advance  = !out_valid || out_ready;
  assign in_ready = !op_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      op_valid <= 1'b0;
    end else if (in_ready) begin
      op_valid <= in_valid;
    end
    if (in_valid && in_ready) begin
      op_kind <= cpu_alu_pkg::kind_t'(kind);
      op_m    <= operand;
      op_addr <= mem_address;
    end
  end

  always_comb begin
    acc_next   = acc;
    xr_next    = xr;
    yr_next    = yr;
    sp_next    = sp;
    flags_next = flags;
    wr         = 1'b0;
    wd         = 8'h00;
    add_en     = 1'b0;
    add_m      = op_m;
    add_cin    = flags.c;
    cmp_en     = 1'b0;
    cmp_reg    = acc;
    cmp_m      = op_m;
    nz_en      = 1'b0;
    nz_val     = 8'h00;

    case (op_kind)
      cpu_alu_pkg::ADC: add_en = 1'b1;
      cpu_alu_pkg::SBC: begin
        add_en = 1'b1;
        add_m  = ~op_m;
      end
      cpu_alu_pkg::AND_M: begin
        acc_next = acc & op_m;
        nz_en = 1'b1; nz_val = acc_next;
      end
      cpu_alu_pkg::EOR: begin
        acc_next = acc ^ op_m;
        nz_en = 1'b1; nz_val = acc_next;
      end
      cpu_alu_pkg::ORA: begin
        acc_next = acc | op_m;
        nz_en = 1'b1; nz_val = acc_next;
      end
      cpu_alu_pkg::ASL: begin
        wr = 1'b1; wd = {op_m[6:0], 1'b0};
        flags_next.c = op_m[7];
        nz_en = 1'b1; nz_val = wd;
      end
      cpu_alu_pkg::LSR: begin
        wr = 1'b1; wd = {1'b0, op_m[7:1]};
        flags_next.c = op_m[0];
        nz_en = 1'b1; nz_val = wd;
      end
      cpu_alu_pkg::ROL: begin
        wr = 1'b1; wd = {op_m[6:0], flags.c};
        flags_next.c = op_m[7];
        nz_en = 1'b1; nz_val = wd;
      end
      cpu_alu_pkg::ROR: begin
        wr = 1'b1; wd = {flags.c, op_m[7:1]};
        flags_next.c = op_m[0];
        nz_en = 1'b1; nz_val = wd;
      end
      cpu_alu_pkg::BIT: begin
        flags_next.n = op_m[7];
        flags_next.v = op_m[6];
        flags_next.z = (acc & op_m) == 8'h00;
      end
      cpu_alu_pkg::CLC: flags_next.c = 1'b0;
      cpu_alu_pkg::CLI: flags_next.i = 1'b0;
      cpu_alu_pkg::CLD: flags_next.d = 1'b0;
      cpu_alu_pkg::CLV: flags_next.v = 1'b0;
      cpu_alu_pkg::SEC: flags_next.c = 1'b1;
      cpu_alu_pkg::SED: flags_next.d = 1'b1;
      cpu_alu_pkg::SEI: flags_next.i = 1'b1;
      cpu_alu_pkg::CMP: cmp_en = 1'b1;
      cpu_alu_pkg::CPX: begin
        cmp_en = 1'b1; cmp_reg = xr;
      end
      cpu_alu_pkg::CPY: begin
        cmp_en = 1'b1; cmp_reg = yr;
      end
      cpu_alu_pkg::DEC: begin
        wr = 1'b1; wd = op_m - 8'd1;
        nz_en = 1'b1; nz_val = wd;
      end
      cpu_alu_pkg::INC: begin
        wr = 1'b1; wd = op_m + 8'd1;
        nz_en = 1'b1; nz_val = wd;
      end
      cpu_alu_pkg::DEX: begin
        xr_next = xr - 8'd1;
        nz_en = 1'b1; nz_val = xr_next;
      end
      cpu_alu_pkg::DEY: begin
        yr_next = yr - 8'd1;
        nz_en = 1'b1; nz_val = yr_next;
      end
      cpu_alu_pkg::INX: begin
        xr_next = xr + 8'd1;
        nz_en = 1'b1; nz_val = xr_next;
      end
      cpu_alu_pkg::INY: begin
        yr_next = yr + 8'd1;
        nz_en = 1'b1; nz_val = yr_next;
      end
      cpu_alu_pkg::LDA: begin
        acc_next = op_m;
        nz_en = 1'b1; nz_val = op_m;
      end
      cpu_alu_pkg::LDX: begin
        xr_next = op_m;
        nz_en = 1'b1; nz_val = op_m;
      end
      cpu_alu_pkg::LDY: begin
        yr_next = op_m;
        nz_en = 1'b1; nz_val = op_m;
      end
      cpu_alu_pkg::STA: begin
        wr = 1'b1; wd = acc;
      end
      cpu_alu_pkg::STX: begin
        wr = 1'b1; wd = xr;
      end
      cpu_alu_pkg::STY: begin
        wr = 1'b1; wd = yr;
      end
      cpu_alu_pkg::TAX: begin
        xr_next = acc;
        nz_en = 1'b1; nz_val = acc;
      end
      cpu_alu_pkg::TAY: begin
        yr_next = acc;
        nz_en = 1'b1; nz_val = acc;
      end
      cpu_alu_pkg::TSX: begin
        xr_next = sp;
        nz_en = 1'b1; nz_val = sp;
      end
      cpu_alu_pkg::TXA: begin
        acc_next = xr;
        nz_en = 1'b1; nz_val = xr;
      end
      cpu_alu_pkg::TXS: sp_next = xr;
      cpu_alu_pkg::TYA: begin
        acc_next = yr;
        nz_en = 1'b1; nz_val = yr;
      end
      cpu_alu_pkg::ASL_A: begin
        acc_next = {acc[6:0], 1'b0};
        flags_next.c = acc[7];
        nz_en = 1'b1; nz_val = acc_next;
      end
      cpu_alu_pkg::LSR_A: begin
        acc_next = {1'b0, acc[7:1]};
        flags_next.c = acc[0];
        nz_en = 1'b1; nz_val = acc_next;
      end
      cpu_alu_pkg::ROL_A: begin
        acc_next = {acc[6:0], flags.c};
        flags_next.c = acc[7];
        nz_en = 1'b1; nz_val = acc_next;
      end
      cpu_alu_pkg::ROR_A: begin
        acc_next = {flags.c, acc[7:1]};
        flags_next.c = acc[0];
        nz_en = 1'b1; nz_val = acc_next;
      end
      cpu_alu_pkg::DCP: begin
        wr = 1'b1; wd = op_m - 8'd1;
        cmp_en = 1'b1; cmp_m = wd;
      end
      cpu_alu_pkg::LAX: begin
        acc_next = op_m;
        xr_next  = op_m;
        nz_en = 1'b1; nz_val = op_m;
      end
      cpu_alu_pkg::SAX: begin
        wr = 1'b1; wd = acc & xr;
      end
      cpu_alu_pkg::ISB: begin
        wr = 1'b1; wd = op_m + 8'd1;
        add_en = 1'b1; add_m = ~wd;
      end
      cpu_alu_pkg::SLO: begin
        wr = 1'b1; wd = {op_m[6:0], 1'b0};
        flags_next.c = op_m[7];
        acc_next = acc | wd;
        nz_en = 1'b1; nz_val = acc_next;
      end
      cpu_alu_pkg::RLA: begin
        wr = 1'b1; wd = {op_m[6:0], flags.c};
        flags_next.c = op_m[7];
        acc_next = acc & wd;
        nz_en = 1'b1; nz_val = acc_next;
      end
      cpu_alu_pkg::SRE: begin
        wr = 1'b1; wd = {1'b0, op_m[7:1]};
        flags_next.c = op_m[0];
        acc_next = acc ^ wd;
        nz_en = 1'b1; nz_val = acc_next;
      end
      cpu_alu_pkg::RRA: begin
        // rotate carry feeds the add
        wr = 1'b1; wd = {flags.c, op_m[7:1]};
        add_en = 1'b1; add_m = wd; add_cin = op_m[0];
      end
      default: begin
      end
    endcase

    sum  = {1'b0, acc} + {1'b0, add_m} + {8'h00, add_cin};
    diff = {1'b0, cmp_reg} - {1'b0, cmp_m};

    if (add_en) begin
      acc_next     = sum[7:0];
      flags_next.c = sum[8];
      flags_next.v = ~(acc[7] ^ add_m[7]) & (acc[7] ^ sum[7]);
      nz_en  = 1'b1;
      nz_val = sum[7:0];
    end
    if (cmp_en) begin
      flags_next.c = !diff[8];
      nz_en  = 1'b1;
      nz_val = diff[7:0];
    end
    if (nz_en) begin
      flags_next.z = nz_val == 8'h00;
      flags_next.n = nz_val[7];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc       <= 8'h00;
      xr        <= 8'h00;
      yr        <= 8'h00;
      sp        <= cpu_alu_pkg::SP_RESET;
      flags     <= '0;
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= op_valid;
      if (op_valid) begin
        acc   <= acc_next;
        xr    <= xr_next;
        yr    <= yr_next;
        sp    <= sp_next;
        flags <= flags_next;
      end
    end
    if (advance && op_valid) begin
      mem_write     <= wr;
      write_address <= op_addr;
      write_data    <= wd;
      acc_out       <= acc_next;
      x_out         <= xr_next;
      y_out         <= yr_next;
      sp_out        <= sp_next;
      status_out    <= {flags_next.n, flags_next.v, 2'b00,
                        flags_next.d, flags_next.i, flags_next.z, flags_next.c};
    end
  end

endmodule
